FILE: rtl/sensor_uart_frame_receiver_core_assert.svh
// ----------------------------------------------------------------------------
// sensor_uart_frame_receiver_core_assert
// Assertion macros for the sensor UART frame receiver.
// ----------------------------------------------------------------------------
`ifndef SENSOR_UART_FRAME_RECEIVER_CORE_ASSERT_SVH
`define SENSOR_UART_FRAME_RECEIVER_CORE_ASSERT_SVH
`ifndef SYNTH
`define SUFR_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("assert");
`define SUFR_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("assert");
`else
`define SUFR_ASSERT_IMPL(label, a, c)
`define SUFR_ASSERT_NEXT(label, a, c)
`endif
`endif

FILE: rtl/sufr_pkg.sv
// ----------------------------------------------------------------------------
// sufr_pkg
// Shared types and constants of the sensor UART frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none
package sufr_pkg;
  localparam int FRAME_BYTES_DEF = 128;
  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CMD_MEAS = 8'h4D;
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LEN   = 2'd1;
  localparam logic [1:0] ST_CSUM  = 2'd2;
  localparam logic [1:0] ST_OVF   = 2'd3;
  localparam logic [19:0] MILLION = 20'd1000000;

  // Word passed from the parser to the decoder.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  command;
    logic        meas;
    logic [15:0] sensor_error;
    logic [31:0] raw;
  } frame_t;
endpackage
`default_nettype wire

FILE: rtl/sufr_fifo.sv
// ----------------------------------------------------------------------------
// sufr_fifo
// Two-entry queue between the parser and the decoder.
// ----------------------------------------------------------------------------
`default_nettype none
module sufr_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_valid,
  input  wire sufr_pkg::frame_t wr_data,
  output logic                  full,
  output logic                  rd_valid,
  output sufr_pkg::frame_t      rd_data,
  input  wire logic             rd_take
);
  sufr_pkg::frame_t mem [2];
  logic       wp, rp;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rp];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_valid && !full) wp <= ~wp;
      if (rd_take && rd_valid) rp <= ~rp;
      count <= count + 2'((wr_valid && !full) ? 1 : 0) - 2'((rd_take && rd_valid) ? 1 : 0);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid && !full) mem[wp] <= wr_data;
  end
endmodule
`default_nettype wire

FILE: rtl/sufr_parser.sv
// ----------------------------------------------------------------------------
// sufr_parser
// Hunts for the frame start, collects bytes, checks length and checksum.
// ----------------------------------------------------------------------------
`default_nettype none
module sufr_parser #(
  parameter int FRAME_BYTES = sufr_pkg::FRAME_BYTES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         byte_valid,
  input  wire logic [7:0]   byte_data,
  output logic              frame_valid,
  output sufr_pkg::frame_t  frame
);
  logic        in_frame;
  logic [7:0]  byte_count;
  logic [7:0]  lagged_sum;
  logic [7:0]  r0, r1, r2;
  logic [23:0] header_fields;
  logic [47:0] payload_bytes;

  logic [7:0]  sum_next, r1_next;
  logic [23:0] hdr_next;
  logic [47:0] pay_next;
  logic [15:0] len;
  logic [8:0]  cnt_next;
  logic        overflow;

  assign overflow = (byte_count >= 8'(FRAME_BYTES));

  // Byte store with lagged checksum
  always_comb begin
    sum_next = (byte_count >= 8'd3) ? lagged_sum + r2 : lagged_sum;
    r1_next  = r0;
    hdr_next = header_fields;
    pay_next = payload_bytes;
    if (byte_count >= 8'd1 && byte_count <= 8'd3)
      hdr_next[8*(byte_count[1:0]-2'd1) +: 8] = byte_data;
    else if (byte_count >= 8'd4 && byte_count <= 8'd9)
      pay_next[8*(byte_count[3:0]-4'd4) +: 8] = byte_data;
    cnt_next = {1'b0, byte_count} + 9'd1;
    len      = hdr_next[23:8];
  end

  // Frame word
  always_comb begin
    frame = '0;
    frame.command = header_fields[7:0];
    frame_valid = 1'b0;
    if (byte_valid && in_frame) begin
      if (overflow) begin
        frame_valid  = 1'b1;
        frame.status = sufr_pkg::ST_OVF;
      end else if (byte_data == sufr_pkg::CH_CLOSE) begin
        frame_valid   = 1'b1;
        frame.command = hdr_next[7:0];
        if (len < 16'd6 || len != {7'd0, cnt_next})
          frame.status = sufr_pkg::ST_LEN;
        else if (r1_next != 8'(8'd0 - sum_next))
          frame.status = sufr_pkg::ST_CSUM;
        else
          frame.status = sufr_pkg::ST_OK;
        if (frame.status == sufr_pkg::ST_OK && hdr_next[7:0] == sufr_pkg::CMD_MEAS) begin
          frame.meas         = 1'b1;
          frame.sensor_error = pay_next[15:0];
          frame.raw          = pay_next[47:16];
        end
      end
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      byte_count <= '0;
      lagged_sum <= '0;
      r0 <= '0; r1 <= '0; r2 <= '0;
      header_fields <= '0;
      payload_bytes <= '0;
    end else if (byte_valid) begin
      if (!in_frame) begin
        if (byte_data == sufr_pkg::CH_OPEN) begin
          in_frame <= 1'b1;
          byte_count <= 8'd1;
          lagged_sum <= '0;
          r0 <= byte_data; r1 <= '0; r2 <= '0;
          header_fields <= '0;
          payload_bytes <= '0;
        end
      end else if (overflow || byte_data == sufr_pkg::CH_CLOSE) begin
        in_frame <= 1'b0;
      end else begin
        byte_count <= cnt_next[7:0];
        lagged_sum <= sum_next;
        r2 <= r1; r1 <= r1_next; r0 <= byte_data;
        header_fields <= hdr_next;
        payload_bytes <= pay_next;
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sufr_decode.sv
// ----------------------------------------------------------------------------
// sufr_decode
// Pipelined float to integer and millionths decode with output register.
// ----------------------------------------------------------------------------
`default_nettype none
module sufr_decode (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire sufr_pkg::frame_t  in_frame,
  output logic                   in_take,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             frame_status,
  output logic [7:0]             command,
  output logic                   is_measurement,
  output logic [15:0]            sensor_error,
  output logic [31:0]            conc_raw,
  output logic signed [31:0]     conc_integer,
  output logic signed [20:0]     conc_millionths
);
  // Stage 1: shift mantissa
  logic              v1;
  sufr_pkg::frame_t  f1;
  logic [31:0]       mag1;
  logic [42:0]       frac1;
  logic              sat1, neg1;
  // Stage 2: millionths product
  logic              v2;
  sufr_pkg::frame_t  f2;
  logic [31:0]       mag2;
  logic              neg2;
  logic [62:0]       prod2;
  logic              adv;

  logic [7:0]  e;
  logic [23:0] m;
  logic [73:0] wide;
  logic [31:0] mag_c;
  logic [42:0] frac_c;
  logic        sat_c;
  logic [19:0] fr;

  assign adv     = !(out_valid && out_stall);
  assign in_take = adv && in_valid;
  assign fr      = prod2[62:43];

  // value = m * 2^(e-150); wide holds it with 43 fraction bits, enough for any
  // fraction that can still reach one millionth; smaller values decode to zero
  always_comb begin
    e = in_frame.raw[30:23];
    m = {1'b1, in_frame.raw[22:0]};
    wide = '0; sat_c = 1'b0;
    if (e == 8'd255) begin
      sat_c = (in_frame.raw[22:0] == 23'd0);
    end else if (e >= 8'd158) begin
      sat_c = 1'b1;
    end else if (e >= 8'd107) begin
      wide = {50'd0, m} << (e - 8'd107);
    end
    mag_c  = {1'b0, wide[73:43]};
    frac_c = wide[42:0];
  end

  // Pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1 <= in_frame; mag1 <= mag_c; frac1 <= frac_c;
      sat1 <= sat_c; neg1 <= in_frame.raw[31];
      f2 <= f1; neg2 <= neg1;
      mag2 <= sat1 ? (neg1 ? 32'h8000_0000 : 32'h7FFF_FFFF) : mag1;
      prod2 <= sat1 ? 63'd0 : {20'd0, frac1} * {43'd0, sufr_pkg::MILLION};
      frame_status   <= f2.status;
      command        <= f2.command;
      is_measurement <= f2.meas;
      sensor_error   <= f2.meas ? f2.sensor_error : 16'd0;
      conc_raw       <= f2.meas ? f2.raw : 32'd0;
      if (!f2.meas) begin
        conc_integer <= '0; conc_millionths <= '0;
      end else if (mag2[31]) begin
        conc_integer <= signed'(mag2); conc_millionths <= '0;
      end else begin
        conc_integer    <= neg2 ? -signed'(mag2) : signed'(mag2);
        conc_millionths <= neg2 ? -signed'({1'b0, fr}) : signed'({1'b0, fr});
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sensor_uart_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// Sensor UART frame receiver.
// Input channel: one received word per accepted cycle on rx_byte (valid/stall).
// Output channel: one result word per frame on valid/stall with status, command
// and, for a good measurement frame, error code, raw float and decoded value.
// The parser takes one word every cycle unless the queue is full; it collects
// a frame from '{' to '}', keeps a running lagged checksum and emits a frame
// word at the closing byte or on overflow. A two-entry queue separates the
// parser from a three-stage decode pipeline (shift, multiply by one million,
// negate and register). Throughput is one word per cycle while not stalled;
// a frame yields one result.
// When the receiver stalls, the decode pipeline holds, the queue fills, and
// stall is raised on the input once the queue is full.
// Reset clears the hunt state, the queue and the pipeline valid bits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sensor_uart_frame_receiver_core_assert.svh"
module sensor_uart_frame_receiver_core #(
  parameter int FRAME_BYTES = sufr_pkg::FRAME_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        rx_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             frame_status,
  output logic [7:0]             command,
  output logic                   is_measurement,
  output logic [15:0]            sensor_error,
  output logic [31:0]            conc_raw,
  output logic signed [31:0]     conc_integer,
  output logic signed [20:0]     conc_millionths
);
  logic             full, fv, qv, qtake;
  sufr_pkg::frame_t fw, qw;

  assign in_stall = full;

  sufr_parser #(.FRAME_BYTES(FRAME_BYTES)) u_parser (
    .clk, .rst, .byte_valid(in_valid && !full), .byte_data(rx_byte),
    .frame_valid(fv), .frame(fw));

  sufr_fifo u_fifo (
    .clk, .rst, .wr_valid(fv), .wr_data(fw), .full, .rd_valid(qv),
    .rd_data(qw), .rd_take(qtake));

  sufr_decode u_decode (
    .clk, .rst, .in_valid(qv), .in_frame(qw), .in_take(qtake),
    .out_valid, .out_stall, .frame_status, .command, .is_measurement,
    .sensor_error, .conc_raw, .conc_integer, .conc_millionths);

  // Checks
  `SUFR_ASSERT_IMPL(a_meas_ok, out_valid && is_measurement, frame_status == sufr_pkg::ST_OK)
  `SUFR_ASSERT_IMPL(a_no_meas_zero, out_valid && !is_measurement, conc_raw == 32'd0)
  `SUFR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
endmodule
`default_nettype wire
